@@ rtl/bdhr_pkg.sv @@
// ----------------------------------------------------------------------------
// bdhr_pkg
// Shared constants for the button debouncer with hold and release detection:
// field widths, packing positions, command codes and register indexes.
// ----------------------------------------------------------------------------
package bdhr_pkg;

	localparam int BUTTONS_DEF   = 3;
	localparam int TIME_BITS_DEF = 32;

	// Pin, edge and polarity fields cover the low three buttons.
	localparam int PIN_W    = 3;
	localparam int CMD_W    = 2;
	localparam int BTN_W    = 2;
	localparam int NOW_W    = 32;
	localparam int LIMIT_W  = 32;
	localparam int DEB_W    = 10;

	// Command codes carried in s_tuser.
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_HOLD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESYNC  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DEB_W;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 1'd1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd20;
	localparam logic [PIN_W-1:0] ACTIVE_RESET   = 3'd0;

	// Input tdata layout, lowest bit first.
	localparam int NOW_LSB    = 0;
	localparam int PINS_LSB   = NOW_LSB + NOW_W;
	localparam int EDGES_LSB  = PINS_LSB + PIN_W;
	localparam int BTN_LSB    = EDGES_LSB + PIN_W;
	localparam int LIMLO_LSB  = BTN_LSB + BTN_W;
	localparam int LIMHI_LSB  = LIMLO_LSB + LIMIT_W;
	localparam int IN_USED_W  = LIMHI_LSB + LIMIT_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	// Output tdata layout, lowest bit first.
	localparam int OUT_HIT_BIT  = 0;
	localparam int OUT_MASK_LSB = 1;
	localparam int OUT_ANY_BIT  = OUT_MASK_LSB + PIN_W;
	localparam int OUT_USED_W   = OUT_ANY_BIT + 1;
	localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

@@ rtl/button_debounce_hold_release.sv @@
// ----------------------------------------------------------------------------
// button_debounce_hold_release
// Debounces a set of buttons and answers hold and release queries. One item
// is taken per clock cycle when the result side keeps up; an accepted item
// is held in an input register, all buttons are updated in parallel by the
// logic behind it, and the answer lands in a result register. The
// combinational update of the per-button state between the two registers
// sets this rate of one item per cycle. The input side keeps accepting while
// a result waits to be taken, and stalls only when both the input and the
// result register are full and the result is not taken in that cycle.
// ----------------------------------------------------------------------------
module button_debounce_hold_release #(
	parameter int BUTTONS   = bdhr_pkg::BUTTONS_DEF,
	parameter int TIME_BITS = bdhr_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bdhr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bdhr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// now_ms, pin_levels, edge_flags, button, limit_low_ms, limit_high_ms
	input  logic [bdhr_pkg::IN_TDATA_W-1:0]       s_tdata,
	// cmd
	input  logic [bdhr_pkg::CMD_W-1:0]            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// hit, down_mask, any_down, zero fill
	output logic [bdhr_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	localparam int PW = bdhr_pkg::PIN_W;

	typedef logic [TIME_BITS-1:0] time_t;

	// Configuration.
	logic [bdhr_pkg::DEB_W-1:0] debounce_q;
	logic [PW-1:0]              active_q;

	// Input register.
	logic                            valid_s1;
	logic [bdhr_pkg::CMD_W-1:0]      cmd_s1;
	time_t                           now_s1;
	logic [PW-1:0]                   pins_s1;
	logic [PW-1:0]                   edges_s1;
	logic [bdhr_pkg::BTN_W-1:0]      button_s1;
	logic [bdhr_pkg::LIMIT_W-1:0]    lim_lo_s1;
	logic [bdhr_pkg::LIMIT_W-1:0]    lim_hi_s1;

	// Per-button state.
	logic [BUTTONS-1:0] raw_q, stable_q, hold_done_q, rel_wait_q;
	time_t              raw_since_q [BUTTONS];
	time_t              press_start_q [BUTTONS];
	time_t              rel_len_q [BUTTONS];

	logic [BUTTONS-1:0] raw_n, stable_n, hold_done_n, rel_wait_n;
	time_t              raw_since_n [BUTTONS];
	time_t              press_start_n [BUTTONS];
	time_t              rel_len_n [BUTTONS];

	// Result register.
	logic                             out_valid_q;
	logic [bdhr_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic in_accept, advance;
	logic hit;
	logic [BUTTONS-1:0] pins_x, edges_x, act_x, lvl, sel;
	logic [BUTTONS+PW-1:0] pins_w, edges_w, act_w;
	logic [BUTTONS+PW-1:0] stable_w;
	logic [PW-1:0] down_mask;
	logic any_down;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Buttons past the pin fields see those bits as zero.
	assign pins_w  = {{BUTTONS{1'b0}}, pins_s1};
	assign edges_w = {{BUTTONS{1'b0}}, edges_s1};
	assign act_w   = {{BUTTONS{1'b0}}, active_q};
	assign pins_x  = pins_w[BUTTONS-1:0];
	assign edges_x = edges_w[BUTTONS-1:0];
	assign act_x   = act_w[BUTTONS-1:0];
	assign lvl     = ~(pins_x ^ act_x);

	always_comb begin
		time_t since_v;
		time_t elapsed;
		time_t held;
		logic  restart;
		logic  settle;
		logic  hold_ok;
		logic  rel_ok;
		raw_n       = raw_q;
		stable_n    = stable_q;
		hold_done_n = hold_done_q;
		rel_wait_n  = rel_wait_q;
		hit         = 1'b0;
		for (int i = 0; i < BUTTONS; i++) begin
			raw_since_n[i]   = raw_since_q[i];
			press_start_n[i] = press_start_q[i];
			rel_len_n[i]     = rel_len_q[i];
			sel[i]           = (int'(button_s1) == i);

			restart = edges_x[i] || (lvl[i] != raw_q[i]);
			since_v = restart ? now_s1 : raw_since_q[i];
			elapsed = now_s1 - since_v;
			settle  = ((restart ? lvl[i] : raw_q[i]) != stable_q[i]) &&
				($signed(elapsed) >= $signed(TIME_BITS'(debounce_q)));

			held    = now_s1 - press_start_q[i];
			hold_ok = stable_q[i] && !hold_done_q[i] &&
				($signed(held) >= $signed(lim_lo_s1[TIME_BITS-1:0]));
			rel_ok  = rel_wait_q[i] &&
				(bdhr_pkg::LIMIT_W'(rel_len_q[i]) >= lim_lo_s1) &&
				(bdhr_pkg::LIMIT_W'(rel_len_q[i]) < lim_hi_s1);

			unique case (cmd_s1)
				bdhr_pkg::CMD_SAMPLE: begin
					raw_n[i]       = restart ? lvl[i] : raw_q[i];
					raw_since_n[i] = since_v;
					if (settle) begin
						stable_n[i] = raw_n[i];
						if (raw_n[i]) begin
							press_start_n[i] = since_v;
							hold_done_n[i]   = 1'b0;
							rel_wait_n[i]    = 1'b0;
						end else begin
							rel_len_n[i]  = since_v - press_start_q[i];
							rel_wait_n[i] = 1'b1;
						end
					end
				end
				bdhr_pkg::CMD_HOLD: begin
					if (sel[i] && hold_ok) begin
						hold_done_n[i] = 1'b1;
						hit            = 1'b1;
					end
				end
				bdhr_pkg::CMD_RELEASE: begin
					if (sel[i] && rel_ok) begin
						rel_wait_n[i] = 1'b0;
						hit           = 1'b1;
					end
				end
				bdhr_pkg::CMD_RESYNC: begin
					raw_n[i]         = lvl[i];
					stable_n[i]      = lvl[i];
					raw_since_n[i]   = now_s1;
					press_start_n[i] = now_s1;
					hold_done_n[i]   = lvl[i];
					rel_wait_n[i]    = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign stable_w  = {{PW{1'b0}}, stable_n};
	assign down_mask = stable_w[PW-1:0];
	assign any_down  = |stable_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bdhr_pkg::DEBOUNCE_RESET;
			active_q   <= bdhr_pkg::ACTIVE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdhr_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data;
				bdhr_pkg::CFG_ACTIVE:   active_q   <= cfg_data[PW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1    <= s_tuser;
			now_s1    <= s_tdata[bdhr_pkg::NOW_LSB +: TIME_BITS];
			pins_s1   <= s_tdata[bdhr_pkg::PINS_LSB +: PW];
			edges_s1  <= s_tdata[bdhr_pkg::EDGES_LSB +: PW];
			button_s1 <= s_tdata[bdhr_pkg::BTN_LSB +: bdhr_pkg::BTN_W];
			lim_lo_s1 <= s_tdata[bdhr_pkg::LIMLO_LSB +: bdhr_pkg::LIMIT_W];
			lim_hi_s1 <= s_tdata[bdhr_pkg::LIMHI_LSB +: bdhr_pkg::LIMIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q       <= '0;
			stable_q    <= '0;
			hold_done_q <= '0;
			rel_wait_q  <= '0;
			for (int i = 0; i < BUTTONS; i++) begin
				raw_since_q[i]   <= '0;
				press_start_q[i] <= '0;
				rel_len_q[i]     <= '0;
			end
		end else if (advance) begin
			raw_q       <= raw_n;
			stable_q    <= stable_n;
			hold_done_q <= hold_done_n;
			rel_wait_q  <= rel_wait_n;
			for (int i = 0; i < BUTTONS; i++) begin
				raw_since_q[i]   <= raw_since_n[i];
				press_start_q[i] <= press_start_n[i];
				rel_len_q[i]     <= rel_len_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Packed as hit, down_mask, any_down from the lowest bit, zero above.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= bdhr_pkg::OUT_TDATA_W'({any_down, down_mask, hit});
		end
	end

endmodule

@@ rtl/bdhr_checker.sv @@
// ----------------------------------------------------------------------------
// bdhr_checker
// Port-level checks for the button debouncer: flow through the two
// registers, result holding under stall and consistency of the pressed flags.
// ----------------------------------------------------------------------------
module bdhr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bdhr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	// Transactions accepted but not yet delivered.
	logic [1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
		end
	end

	// With the result register empty the input side never stalls.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 2'd0)
		else $error("result shown with no transaction outstanding");

	// Only the input and result registers may hold transactions.
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more than two transactions in flight");

	a_any_down: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[bdhr_pkg::OUT_MASK_LSB +: bdhr_pkg::PIN_W] != '0)
			|-> m_tdata[bdhr_pkg::OUT_ANY_BIT])
		else $error("pressed button without any_down");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind button_debounce_hold_release bdhr_checker u_bdhr_checker (.*);
